// File: rtl/atsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atsp_pkg
// Shared types, byte codes and helpers for the Adalight / TPM2 stream parser.
// ----------------------------------------------------------------------------
package atsp_pkg;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_HDR_D    = 4'd1,
    ST_HDR_A2   = 4'd2,
    ST_ADA_HI   = 4'd3,
    ST_ADA_LO   = 4'd4,
    ST_ADA_CHK  = 4'd5,
    ST_RED      = 4'd6,
    ST_GREEN    = 4'd7,
    ST_BLUE     = 4'd8,
    ST_TPM_TYPE = 4'd9,
    ST_TPM_HI   = 4'd10,
    ST_TPM_LO   = 4'd11
  } parse_state_e;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_PIXEL     = 4'd1,
    EV_PING      = 4'd2,
    EV_BAUD      = 4'd3,
    EV_JSON_DUMP = 4'd4,
    EV_BYTE_DUMP = 4'd5,
    EV_VERSION   = 4'd6,
    EV_RECONNECT = 4'd7,
    EV_BOOT      = 4'd8,
    EV_IMPROV    = 4'd9,
    EV_JSON      = 4'd10
  } event_e;

  // Received byte codes
  localparam logic [7:0] CH_ADA_A   = 8'h41;  // 'A'
  localparam logic [7:0] CH_ADA_D   = 8'h64;  // 'd'
  localparam logic [7:0] CH_ADA_A2  = 8'h61;  // 'a'
  localparam logic [7:0] CH_TPM_HDR = 8'hC9;
  localparam logic [7:0] CH_TPM_DAT = 8'hDA;
  localparam logic [7:0] CH_TPM_PNG = 8'hAA;
  localparam logic [7:0] CH_IMPROV  = 8'h49;  // 'I'
  localparam logic [7:0] CH_VERSION = 8'h76;  // 'v'
  localparam logic [7:0] CH_BOOT    = 8'h5E;  // '^'
  localparam logic [7:0] CH_RECONN  = 8'h58;  // 'X'
  localparam logic [7:0] CH_JDUMP   = 8'h6C;  // 'l'
  localparam logic [7:0] CH_BDUMP   = 8'h4C;  // 'L'
  localparam logic [7:0] CH_CONT_OFF = 8'h6F; // 'o'
  localparam logic [7:0] CH_CONT_ON = 8'h4F;  // 'O'
  localparam logic [7:0] CH_JSON    = 8'h7B;  // '{'
  localparam logic [7:0] CH_BAUD_LO = 8'hB0;
  localparam logic [7:0] CH_BAUD_HI = 8'hB7;
  localparam logic [7:0] ADA_CHK_KEY = 8'h55;

  typedef struct packed {
    event_e      event_res;
    logic        pixel_write;
    logic [15:0] pixel_index;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        frame_end;
    logic [2:0]  baud_index;
    logic        continuous_mode;
  } atsp_result_t;

  // floor(x / 3) for a byte: multiply by 171, drop 9 bits (exact over 0..255)
  function automatic logic [7:0] div3_u8(input logic [7:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'd171;
    return {1'b0, prod[15:9]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/atsp_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atsp_core
// Parser state and single-pass result logic; state advances on each
// accepted byte.
// ----------------------------------------------------------------------------
module atsp_core
  import atsp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         byte_en_i,
  input  wire logic [7:0]   rx_byte_i,
  input  wire logic         override_i,
  output atsp_result_t      result_o
);

  parse_state_e state_q, state_d;
  logic [15:0]  triples_q, triples_d;
  logic [15:0]  pixel_q, pixel_d;
  logic [7:0]   check_q, check_d;
  logic [7:0]   red_q, red_d;
  logic [7:0]   green_q, green_d;
  logic         cont_q, cont_d;

  logic [15:0]  triples_dec;
  logic [7:0]   b;

  assign b = rx_byte_i;
  assign triples_dec = triples_q - 16'd1;

  always_comb begin
    state_d   = ST_IDLE;
    triples_d = triples_q;
    pixel_d   = pixel_q;
    check_d   = check_q;
    red_d     = red_q;
    green_d   = green_q;
    cont_d    = cont_q;
    result_o  = '0;

    unique case (state_q)
      ST_HDR_D:   state_d = (b == CH_ADA_D) ? ST_HDR_A2 : ST_IDLE;
      ST_HDR_A2:  state_d = (b == CH_ADA_A2) ? ST_ADA_HI : ST_IDLE;
      ST_ADA_HI: begin
        pixel_d   = '0;
        triples_d = {b, 8'h00};
        check_d   = b;
        state_d   = ST_ADA_LO;
      end
      ST_ADA_LO: begin
        triples_d = triples_q + 16'(b) + 16'd1;
        check_d   = check_q ^ b ^ ADA_CHK_KEY;
        state_d   = ST_ADA_CHK;
      end
      ST_ADA_CHK: state_d = (check_q == b) ? ST_RED : ST_IDLE;
      ST_TPM_TYPE: begin
        if (b == CH_TPM_DAT) begin
          state_d = ST_TPM_HI;
        end else if (b == CH_TPM_PNG) begin
          result_o.event_res = EV_PING;
        end
      end
      ST_TPM_HI: begin
        // (b * 256) / 3 = 85 * b + b / 3
        pixel_d   = '0;
        triples_d = 16'(b) * 16'd85 + 16'(div3_u8(b));
        state_d   = ST_TPM_LO;
      end
      ST_TPM_LO: begin
        triples_d = triples_q + 16'(div3_u8(b));
        state_d   = ST_RED;
      end
      ST_RED: begin
        red_d   = b;
        state_d = ST_GREEN;
      end
      ST_GREEN: begin
        green_d = b;
        state_d = ST_BLUE;
      end
      ST_BLUE: begin
        result_o.event_res   = EV_PIXEL;
        result_o.pixel_index = pixel_q;
        result_o.red_out     = red_q;
        result_o.green_out   = green_q;
        result_o.blue_out    = b;
        result_o.pixel_write = ~override_i;
        if (!override_i) begin
          pixel_d = pixel_q + 16'd1;
        end
        triples_d = triples_dec;
        if (triples_dec != '0) begin
          state_d = ST_RED;
        end else begin
          result_o.frame_end = 1'b1;
        end
      end
      default: begin
        // idle, and unused codes behave as idle
        unique case (b)
          CH_ADA_A:    state_d = ST_HDR_D;
          CH_TPM_HDR:  state_d = ST_TPM_TYPE;
          CH_IMPROV:   result_o.event_res = EV_IMPROV;
          CH_VERSION:  result_o.event_res = EV_VERSION;
          CH_BOOT:     result_o.event_res = EV_BOOT;
          CH_RECONN:   result_o.event_res = EV_RECONNECT;
          CH_JDUMP:    result_o.event_res = EV_JSON_DUMP;
          CH_BDUMP:    result_o.event_res = EV_BYTE_DUMP;
          CH_CONT_ON:  cont_d = 1'b1;
          CH_JSON:     result_o.event_res = EV_JSON;
          default: begin
            if (b >= CH_BAUD_LO && b <= CH_BAUD_HI) begin
              result_o.event_res  = EV_BAUD;
              result_o.baud_index = b[2:0];
            end
          end
        endcase
      end
    endcase

    // any byte other than 'O' drops continuous mode ('o' included)
    if (b != CH_CONT_ON) begin
      cont_d = 1'b0;
    end
    result_o.continuous_mode = cont_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      triples_q <= '0;
      pixel_q   <= '0;
      check_q   <= '0;
      red_q     <= '0;
      green_q   <= '0;
      cont_q    <= 1'b0;
    end else if (byte_en_i) begin
      state_q   <= state_d;
      triples_q <= triples_d;
      pixel_q   <= pixel_d;
      check_q   <= check_d;
      red_q     <= red_d;
      green_q   <= green_d;
      cont_q    <= cont_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/adalight_tpm2_stream_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adalight_tpm2_stream_parser_unit
// Parses Adalight and TPM2 framed serial bytes into pixel writes and
// command events, one result per received byte.
// ----------------------------------------------------------------------------
// Output: registered; a result is on m_axis in the cycle after its byte is accepted.
// Throughput: 1 byte per cycle while m_axis keeps up; the parser is a single pass of logic from the
//   parser state registers into one output register.
// Reset (rst_ni low, asynchronous): parser idle, counters and held colors
//   zero, continuous mode off, override off, no result pending.
module adalight_tpm2_stream_parser_unit
  import atsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: override_pixels
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  // received byte stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] pixel_write, [16:1] pixel_index, [24:17] red_out, [32:25] green_out,
  // [40:33] blue_out, [43:41] baud_index, [44] continuous_mode, [47:45] zero
  output logic [47:0]      m_axis_tdata,
  output logic [3:0]       m_axis_tuser,   // [3:0] event_res
  output logic             m_axis_tlast    // frame_end
);

  logic         override_q;
  logic         out_valid_q;
  atsp_result_t res_q;
  atsp_result_t res_d;
  logic         in_accept;

  // The output register frees up in the same cycle it is drained, so a
  // byte can be taken on every clock while the sink keeps up.
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      override_q <= 1'b0;
    end else if (cfg_we_i) begin
      override_q <= cfg_wdata_i;
    end
  end

  atsp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_en_i  (in_accept),
    .rx_byte_i  (s_axis_tdata),
    .override_i (override_q),
    .result_o   (res_d)
  );

  // result register: valid is control, payload loads on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.event_res;
  assign m_axis_tlast  = res_q.frame_end;
  assign m_axis_tdata  = {3'b000,
                          res_q.continuous_mode,
                          res_q.baud_index,
                          res_q.blue_out,
                          res_q.green_out,
                          res_q.red_out,
                          res_q.pixel_index,
                          res_q.pixel_write};

endmodule
`default_nettype wire

// File: rtl/atsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atsp_checker
// Port-level checks on the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module atsp_checker
  import atsp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [3:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // a pixel write only comes with a pixel transaction
  a_write_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tuser == EV_PIXEL))
    else $error("pixel write on non-pixel event");

  // frame end only marks a pixel transaction
  a_last_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == EV_PIXEL))
    else $error("frame end on non-pixel event");

  // pixel fields are zero off pixel events
  a_pixel_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != EV_PIXEL) |-> (m_axis_tdata[40:1] == '0))
    else $error("pixel fields set on non-pixel event");

  // baud index only nonzero on a baud event
  a_baud_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[43:41] != 3'd0) |-> (m_axis_tuser == EV_BAUD))
    else $error("baud index outside baud event");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind adalight_tpm2_stream_parser_unit atsp_checker u_atsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Adalight / TPM2 stream parser. Random and
// directed serial bytes go in, each accepted byte is run through a local
// model of the parser, and every result transaction is compared field by
// field against the oldest predicted one.
// ----------------------------------------------------------------------------
import atsp_pkg::*;

class atsp_result_board;
  bit           override_on;
  parse_state_e state;
  logic [15:0]  triples_left;
  logic [15:0]  next_pix;
  logic [7:0]   check_acc;
  logic [7:0]   red_hold;
  logic [7:0]   green_hold;
  bit           cont_flag;
  atsp_result_t pending_results[$];
  int           mismatches;
  int           checked;

  function new();
    override_on  = 1'b0;
    state        = ST_IDLE;
    triples_left = '0;
    next_pix     = '0;
    check_acc    = '0;
    red_hold     = '0;
    green_hold   = '0;
    cont_flag    = 1'b0;
    mismatches   = 0;
    checked      = 0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // One byte through the parser; returns the result it must produce.
  function atsp_result_t parse_byte(logic [7:0] b);
    atsp_result_t r;
    r = '0;
    case (state)
      ST_HDR_D:   state = (b == CH_ADA_D) ? ST_HDR_A2 : ST_IDLE;
      ST_HDR_A2:  state = (b == CH_ADA_A2) ? ST_ADA_HI : ST_IDLE;
      ST_ADA_HI: begin
        next_pix     = '0;
        triples_left = {b, 8'h00};
        check_acc    = b;
        state        = ST_ADA_LO;
      end
      ST_ADA_LO: begin
        triples_left = triples_left + 16'(b) + 16'd1;
        check_acc    = check_acc ^ b ^ ADA_CHK_KEY;
        state        = ST_ADA_CHK;
      end
      ST_ADA_CHK: state = (check_acc == b) ? ST_RED : ST_IDLE;
      ST_TPM_TYPE: begin
        state = ST_IDLE;
        if (b == CH_TPM_DAT) begin
          state = ST_TPM_HI;
        end else if (b == CH_TPM_PNG) begin
          r.event_res = EV_PING;
        end
      end
      ST_TPM_HI: begin
        next_pix     = '0;
        triples_left = {b, 8'h00} / 16'd3;
        state        = ST_TPM_LO;
      end
      ST_TPM_LO: begin
        triples_left = triples_left + 16'(b / 8'd3);
        state        = ST_RED;
      end
      ST_RED: begin
        red_hold = b;
        state    = ST_GREEN;
      end
      ST_GREEN: begin
        green_hold = b;
        state      = ST_BLUE;
      end
      ST_BLUE: begin
        r.event_res   = EV_PIXEL;
        r.pixel_index = next_pix;
        r.red_out     = red_hold;
        r.green_out   = green_hold;
        r.blue_out    = b;
        if (!override_on) begin
          r.pixel_write = 1'b1;
          next_pix      = next_pix + 16'd1;
        end
        triples_left = triples_left - 16'd1;
        if (triples_left != 16'd0) begin
          state = ST_RED;
        end else begin
          r.frame_end = 1'b1;
          state       = ST_IDLE;
        end
      end
      default: begin
        // idle, and any code outside the used set
        state = ST_IDLE;
        case (b)
          CH_ADA_A:    state = ST_HDR_D;
          CH_TPM_HDR:  state = ST_TPM_TYPE;
          CH_IMPROV:   r.event_res = EV_IMPROV;
          CH_VERSION:  r.event_res = EV_VERSION;
          CH_BOOT:     r.event_res = EV_BOOT;
          CH_RECONN:   r.event_res = EV_RECONNECT;
          CH_JDUMP:    r.event_res = EV_JSON_DUMP;
          CH_BDUMP:    r.event_res = EV_BYTE_DUMP;
          CH_CONT_OFF: cont_flag = 1'b0;
          CH_CONT_ON:  cont_flag = 1'b1;
          CH_JSON:     r.event_res = EV_JSON;
          default: begin
            if (b >= CH_BAUD_LO && b <= CH_BAUD_HI) begin
              r.event_res  = EV_BAUD;
              r.baud_index = 3'(b - CH_BAUD_LO);
            end
          end
        endcase
      end
    endcase
    // 'O' only sets the flag from idle, but every other byte clears it
    if (b != CH_CONT_ON) cont_flag = 1'b0;
    r.continuous_mode = cont_flag;
    return r;
  endfunction

  function void note_byte(logic [7:0] b);
    pending_results.push_back(parse_byte(b));
  endfunction

  function void flag_field(string what, logic [15:0] want, logic [15:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("result %0d: %s expected %0h, got %0h", checked, what, want, got);
    end
  endfunction

  function void check_result(atsp_result_t got);
    atsp_result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result with nothing pending: event %0h", got.event_res);
      end
      return;
    end
    want = pending_results.pop_front();
    if (got.event_res !== want.event_res)
      flag_field("event_res", 16'(want.event_res), 16'(got.event_res));
    if (got.pixel_write !== want.pixel_write)
      flag_field("pixel_write", 16'(want.pixel_write), 16'(got.pixel_write));
    if (got.pixel_index !== want.pixel_index)
      flag_field("pixel_index", want.pixel_index, got.pixel_index);
    if (got.red_out !== want.red_out)
      flag_field("red_out", 16'(want.red_out), 16'(got.red_out));
    if (got.green_out !== want.green_out)
      flag_field("green_out", 16'(want.green_out), 16'(got.green_out));
    if (got.blue_out !== want.blue_out)
      flag_field("blue_out", 16'(want.blue_out), 16'(got.blue_out));
    if (got.frame_end !== want.frame_end)
      flag_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
    if (got.baud_index !== want.baud_index)
      flag_field("baud_index", 16'(want.baud_index), 16'(got.baud_index));
    if (got.continuous_mode !== want.continuous_mode)
      flag_field("continuous_mode", 16'(want.continuous_mode),
                 16'(got.continuous_mode));
    checked++;
  endfunction
endclass

module tb_top;

  localparam int STALL_LIMIT = 1000;  // cycles with no transaction at all

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [47:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  atsp_result_board board;
  bit pace_on     = 1'b1;  // random gaps and stalls on both sides
  int bytes_sent  = 0;
  int quiet_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  adalight_tpm2_stream_parser_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Both handshakes are seen in one process, input first, so the order
  // of prediction and check never depends on scheduling.
  always @(posedge clk_i) begin : monitor
    atsp_result_t got;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        board.note_byte(s_axis_tdata);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got                 = '0;
        got.event_res       = event_e'(m_axis_tuser);
        got.pixel_write     = m_axis_tdata[0];
        got.pixel_index     = m_axis_tdata[16:1];
        got.red_out         = m_axis_tdata[24:17];
        got.green_out       = m_axis_tdata[32:25];
        got.blue_out        = m_axis_tdata[40:33];
        got.baud_index      = m_axis_tdata[43:41];
        got.continuous_mode = m_axis_tdata[44];
        got.frame_end       = m_axis_tlast;
        board.check_result(got);
        moved = 1'b1;
      end
    end
    quiet_count = moved ? 0 : quiet_count + 1;
    if (quiet_count >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: a fresh stall before every transaction.
  initial begin : result_sink
    int stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = pace_on ? $urandom_range(0, 14) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Returns at the edge that accepts the byte; tvalid stays high.
  task automatic push_byte(logic [7:0] b);
    int gap;
    gap = pace_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic push_triples(int n);
    for (int i = 0; i < 3 * n; i++) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_ada(logic [7:0] hi, logic [7:0] lo, bit good);
    logic [7:0] chk;
    chk = hi ^ lo ^ ADA_CHK_KEY;
    if (!good) chk = chk + 8'($urandom_range(1, 255));
    push_byte(CH_ADA_A);
    push_byte(CH_ADA_D);
    push_byte(CH_ADA_A2);
    push_byte(hi);
    push_byte(lo);
    push_byte(chk);
    if (good) push_triples(int'({hi, lo}) + 1);
  endtask

  task automatic send_tpm(logic [7:0] hi, logic [7:0] lo);
    int n;
    n = (int'(hi) * 256) / 3 + int'(lo) / 3;
    if (n == 0) n = 65536;  // count wraps: a full 16-bit frame
    push_byte(CH_TPM_HDR);
    push_byte(CH_TPM_DAT);
    push_byte(hi);
    push_byte(lo);
    push_triples(n);
  endtask

  // Only with the input held off and every result back.
  task automatic write_override(bit v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i          <= 1'b0;
    board.override_on = v;
  endtask

  initial begin : stimulus
    int start;
    int pick;
    logic [7:0] b;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every command, byte extremes, ping, unknown TPM2 type,
    // a one-triple Adalight frame
    write_override(1'b0);
    push_byte(CH_CONT_ON);
    push_byte(CH_CONT_ON);
    push_byte(CH_CONT_OFF);
    push_byte(CH_IMPROV);
    push_byte(CH_VERSION);
    push_byte(CH_BOOT);
    push_byte(CH_RECONN);
    push_byte(CH_BAUD_LO);
    push_byte(CH_BAUD_HI);
    push_byte(CH_JDUMP);
    push_byte(CH_BDUMP);
    push_byte(CH_JSON);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_TPM_HDR);
    push_byte(CH_TPM_PNG);
    push_byte(CH_TPM_HDR);
    push_byte(8'h00);
    send_ada(8'h00, 8'h00, 1'b1);
    write_override(1'b1);
    send_tpm(8'h00, 8'h03);
    write_override(1'b0);

    // random: mostly well-formed frames, some commands, broken headers, noise
    start = bytes_sent;
    while (bytes_sent - start < 500) begin
      pace_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 24) == 0) write_override(1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_ada(8'h00, 8'($urandom_range(0, 7)), 1'b1);
      end else if (pick < 60) begin
        send_tpm(($urandom_range(0, 29) == 0) ? 8'h01 : 8'h00,
                 8'($urandom_range(3, 30)));
      end else if (pick < 70) begin
        push_byte(CH_TPM_HDR);
        push_byte(CH_TPM_PNG);
      end else if (pick < 85) begin
        case ($urandom_range(0, 9))
          0: push_byte(CH_IMPROV);
          1: push_byte(CH_VERSION);
          2: push_byte(CH_BOOT);
          3: push_byte(CH_RECONN);
          4: push_byte(CH_JDUMP);
          5: push_byte(CH_BDUMP);
          6: push_byte(CH_CONT_OFF);
          7: push_byte(CH_CONT_ON);
          8: push_byte(CH_JSON);
          default: push_byte(CH_BAUD_LO + 8'($urandom_range(0, 7)));
        endcase
      end else if (pick < 95) begin
        case ($urandom_range(0, 3))
          0: begin
            push_byte(CH_ADA_A);
            do b = 8'($urandom_range(0, 255)); while (b == CH_ADA_D);
            push_byte(b);
          end
          1: begin
            push_byte(CH_ADA_A);
            push_byte(CH_ADA_D);
            do b = 8'($urandom_range(0, 255)); while (b == CH_ADA_A2);
            push_byte(b);
          end
          2: send_ada(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
          default: begin
            push_byte(CH_TPM_HDR);
            do b = 8'($urandom_range(0, 255)); while (b == CH_TPM_DAT);
            push_byte(b);
          end
        endcase
      end else begin
        // noise that cannot open a frame
        repeat ($urandom_range(1, 4)) begin
          do b = 8'($urandom_range(0, 255));
          while (b == CH_ADA_A || b == CH_TPM_HDR);
          push_byte(b);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
